### src/lsfd_pkg.sv
// Shared types and constants for the LED shift-register frame driver.
package lsfd_pkg;

    // Field widths of the bus words.
    localparam int OP_W          = 3;
    localparam int CHIP_FIELD_W  = 3;
    localparam int CH_W          = 4;
    localparam int LED_W         = 7;
    localparam int WORD_W        = 16;
    localparam int BRIGHT_W      = 7;
    localparam int OE_W          = 10;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 7;

    // One driver chip carries sixteen channels.
    localparam int CHANNELS      = 16;

    // Word patterns.
    localparam logic [WORD_W-1:0] WORD_ZERO = 16'h0000;
    localparam logic [WORD_W-1:0] WORD_ONES = 16'hFFFF;
    localparam logic [WORD_W-1:0] WORD_BIT0 = 16'h0001;

    // Configuration reset values and the brightness ceiling in percent.
    localparam logic                LSB_FIRST_RESET       = 1'b0;
    localparam logic                LAST_CHIP_FIRST_RESET = 1'b1;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET          = 7'd10;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX            = 7'd100;
    localparam logic                OE_ENABLE_RESET       = 1'b0;

    // Compare arithmetic: brightness * (period % 100) stays below 10000, and
    // that product is divided by 100 as a multiply by ceil(2^20 / 100).
    localparam int                REM_W       = 14;
    localparam int                PROD_W      = 23;
    localparam int                RECIP_SHIFT = 20;
    localparam logic [REM_W-1:0]  RECIP_MULT  = 14'd10486;

    // Bus operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_SET_CHANNEL = 3'd0,
        OP_SET_LINEAR  = 3'd1,
        OP_WRITE_WORD  = 3'd2,
        OP_CLEAR       = 3'd3,
        OP_FILL        = 3'd4,
        OP_REFRESH     = 3'd5,
        OP_READ        = 3'd6
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LSB_FIRST       = 2'd0,
        CFG_LAST_CHIP_FIRST = 2'd1,
        CFG_BRIGHTNESS      = 2'd2,
        CFG_OUTPUT_ENABLE   = 2'd3
    } t_cfg_index;

    // Controller states.
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SHIFT = 1'b1
    } t_state;

    // Input word.
    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic [CHIP_FIELD_W-1:0] chip_index;
        logic [CH_W-1:0]         channel;
        logic [LED_W-1:0]        led_index;
        logic                    light_on;
        logic [WORD_W-1:0]       word_data;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] read_data;
        logic              serial_bit;
        logic              bit_valid;
        logic              last;
        logic [OE_W-1:0]   oe_compare;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic op_exec;
        logic shift_load;
        logic shift_emit;
        logic emit_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

### src/lsfd_ctrl.sv
// Controller: input handshake and the refresh bit sequencer.
module lsfd_ctrl #(
    parameter int CHIPS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [lsfd_pkg::OP_W-1:0]  i_opcode,
    output logic                       o_in_ready,
    input  lsfd_pkg::t_dp_status       i_status,
    output lsfd_pkg::t_dp_cmd          o_cmd
);

    localparam int BitCount = CHIPS * lsfd_pkg::CHANNELS;
    localparam int CntW     = $clog2(BitCount);
    localparam logic [CntW-1:0] CntLast = CntW'(BitCount - 1);

    lsfd_pkg::t_state r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;

    // State and bit counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsfd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lsfd_pkg::ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_opcode == lsfd_pkg::OP_REFRESH) begin
                        o_cmd.shift_load = 1'b1;
                        n_cnt            = '0;
                        n_state          = lsfd_pkg::ST_SHIFT;
                    end else begin
                        o_cmd.op_exec = 1'b1;
                    end
                end
            end
            lsfd_pkg::ST_SHIFT: begin
                // One bit goes out each cycle the output register is free.
                if (i_status.out_free) begin
                    o_cmd.shift_emit = 1'b1;
                    o_cmd.emit_last  = (r_cnt == CntLast);
                    if (r_cnt == CntLast) begin
                        n_state = lsfd_pkg::ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = lsfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/lsfd_dp.sv
// Datapath: frame store, configuration, refresh shifter and result register.
module lsfd_dp #(
    parameter int CHIPS      = 4,
    parameter int PWM_PERIOD = 1000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lsfd_pkg::t_dp_cmd                 i_cmd,
    output lsfd_pkg::t_dp_status              o_status,
    input  lsfd_pkg::t_in_word                i_in_word,
    input  logic                              i_cfg_we,
    input  logic [lsfd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lsfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output lsfd_pkg::t_out_word               o_out_word
);

    localparam int ChipW    = (CHIPS > 1) ? $clog2(CHIPS) : 1;
    localparam int BitCount = CHIPS * lsfd_pkg::CHANNELS;
    localparam int PwmQuot  = PWM_PERIOD / 100;
    localparam int PwmRem   = PWM_PERIOD % 100;
    localparam logic [lsfd_pkg::REM_W-1:0] RemReset =
        lsfd_pkg::REM_W'(int'(lsfd_pkg::BRIGHT_RESET) * PwmRem);
    localparam int RemProdW = 2 * lsfd_pkg::REM_W;

    // Frame store and configuration registers.
    logic [lsfd_pkg::WORD_W-1:0]   r_store [CHIPS];
    logic [lsfd_pkg::WORD_W-1:0]   n_store [CHIPS];
    logic                          r_lsb_first;
    logic                          r_last_chip_first;
    logic [lsfd_pkg::BRIGHT_W-1:0] r_bright;
    logic [lsfd_pkg::REM_W-1:0]    r_bright_rem;
    logic                          r_oe_enable;

    // Refresh shifter and result register.
    logic [BitCount-1:0]           r_sr, n_sr;
    logic                          r_out_valid;
    lsfd_pkg::t_out_word           r_out_word, n_out_word;

    logic [lsfd_pkg::CHIP_FIELD_W-1:0] w_sel_chip;
    logic [ChipW-1:0]                  w_sel_idx;
    logic                              w_sel_ok;
    logic [lsfd_pkg::CH_W-1:0]         w_sel_bit;
    logic [lsfd_pkg::WORD_W-1:0]       w_cur, w_mask, n_read;
    logic                              n_status;
    logic [lsfd_pkg::BRIGHT_W-1:0]     w_cfg_bright;
    logic [RemProdW-1:0]               w_rem_prod;
    logic [lsfd_pkg::PROD_W-1:0]       w_comp_full;
    logic [lsfd_pkg::OE_W-1:0]         w_compare;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

    // Address of the addressed word and bit: a linear index splits into
    // chip (upper bits) and channel (low four bits).
    assign w_sel_chip = (i_in_word.opcode == lsfd_pkg::OP_SET_LINEAR)
                      ? i_in_word.led_index[lsfd_pkg::LED_W-1:lsfd_pkg::CH_W]
                      : i_in_word.chip_index;
    assign w_sel_bit  = (i_in_word.opcode == lsfd_pkg::OP_SET_LINEAR)
                      ? i_in_word.led_index[lsfd_pkg::CH_W-1:0]
                      : i_in_word.channel;
    assign w_sel_ok   = (w_sel_chip < lsfd_pkg::CHIP_FIELD_W'(CHIPS));
    assign w_sel_idx  = w_sel_chip[ChipW-1:0];
    assign w_cur      = r_store[w_sel_idx];
    assign w_mask     = lsfd_pkg::WORD_BIT0 << w_sel_bit;

    // Bus operation decode: store update, status and read data.
    always_comb begin
        n_store  = r_store;
        n_status = 1'b0;
        n_read   = lsfd_pkg::WORD_ZERO;
        unique case (i_in_word.opcode) inside
            lsfd_pkg::OP_SET_CHANNEL, lsfd_pkg::OP_SET_LINEAR: begin
                if (w_sel_ok) begin
                    n_store[w_sel_idx] = i_in_word.light_on ? (w_cur | w_mask)
                                                            : (w_cur & ~w_mask);
                end else begin
                    n_status = 1'b1;
                end
            end
            lsfd_pkg::OP_WRITE_WORD: begin
                if (w_sel_ok) begin
                    n_store[w_sel_idx] = i_in_word.word_data;
                end else begin
                    n_status = 1'b1;
                end
            end
            lsfd_pkg::OP_CLEAR: begin
                for (int i = 0; i < CHIPS; i++) begin
                    n_store[i] = lsfd_pkg::WORD_ZERO;
                end
            end
            lsfd_pkg::OP_FILL: begin
                for (int i = 0; i < CHIPS; i++) begin
                    n_store[i] = lsfd_pkg::WORD_ONES;
                end
            end
            lsfd_pkg::OP_READ: begin
                if (w_sel_ok) begin
                    n_read = w_cur;
                end else begin
                    n_status = 1'b1;
                end
            end
            lsfd_pkg::OP_REFRESH: begin
                n_status = 1'b0;
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
    end

    // Serial order of the whole frame: bit 0 of the vector goes out first.
    always_comb begin
        n_sr = r_sr >> 1;
        if (i_cmd.shift_load) begin
            for (int n = 0; n < CHIPS; n++) begin
                for (int b = 0; b < lsfd_pkg::CHANNELS; b++) begin
                    n_sr[n * lsfd_pkg::CHANNELS + b] =
                        r_store[r_last_chip_first ? (CHIPS - 1 - n) : n]
                               [r_lsb_first ? b : (lsfd_pkg::CHANNELS - 1 - b)];
                end
            end
        end
    end

    // Compare value: b*P/100 = b*(P/100) + (b*(P%100))/100, where the
    // second product was formed when brightness was written.
    assign w_rem_prod  = RemProdW'(r_bright_rem) * RemProdW'(lsfd_pkg::RECIP_MULT);
    assign w_comp_full = lsfd_pkg::PROD_W'(r_bright) * lsfd_pkg::PROD_W'(PwmQuot)
                       + lsfd_pkg::PROD_W'(w_rem_prod[RemProdW-1:lsfd_pkg::RECIP_SHIFT]);
    assign w_compare   = r_oe_enable ? w_comp_full[lsfd_pkg::OE_W-1:0] : '0;

    // Next result word.
    always_comb begin
        n_out_word            = '0;
        n_out_word.oe_compare = w_compare;
        if (i_cmd.shift_emit) begin
            n_out_word.serial_bit = r_sr[0];
            n_out_word.bit_valid  = 1'b1;
            n_out_word.last       = i_cmd.emit_last;
        end else begin
            n_out_word.status    = n_status;
            n_out_word.read_data = n_read;
            n_out_word.last      = 1'b1;
        end
    end

    // Brightness writes above the ceiling clamp to it.
    assign w_cfg_bright = (i_cfg_data > lsfd_pkg::BRIGHT_MAX) ? lsfd_pkg::BRIGHT_MAX
                                                              : i_cfg_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_first       <= lsfd_pkg::LSB_FIRST_RESET;
            r_last_chip_first <= lsfd_pkg::LAST_CHIP_FIRST_RESET;
            r_bright          <= lsfd_pkg::BRIGHT_RESET;
            r_bright_rem      <= RemReset;
            r_oe_enable       <= lsfd_pkg::OE_ENABLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsfd_pkg::CFG_LSB_FIRST:       r_lsb_first       <= i_cfg_data[0];
                lsfd_pkg::CFG_LAST_CHIP_FIRST: r_last_chip_first <= i_cfg_data[0];
                lsfd_pkg::CFG_BRIGHTNESS: begin
                    r_bright     <= w_cfg_bright;
                    r_bright_rem <= lsfd_pkg::REM_W'(w_cfg_bright)
                                  * lsfd_pkg::REM_W'(PwmRem);
                end
                lsfd_pkg::CFG_OUTPUT_ENABLE:   r_oe_enable       <= i_cfg_data[0];
                default: begin
                    r_oe_enable <= r_oe_enable;
                end
            endcase
        end
    end

    // Frame store: cleared at reset, updated by bus operations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHIPS; i++) begin
                r_store[i] <= lsfd_pkg::WORD_ZERO;
            end
        end else if (i_cmd.op_exec) begin
            r_store <= n_store;
        end
    end

    // Refresh shifter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_load || i_cmd.shift_emit) begin
            r_sr <= n_sr;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op_exec || i_cmd.shift_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op_exec || i_cmd.shift_emit) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

### src/led_shift_register_frame_driver.sv
// A non-refresh bus word's single result is written to the output register as the word is accepted.
// Throughput: one non-refresh word per cycle while the output side takes results.
// A refresh gives CHIPS*16 bit words, one per cycle while the output side takes them, paced by the
// controller's bit counter; the input is held off until the last bit has entered the output register.
// Reset (synchronous, active low) clears the frame store and the output valid flag and
// returns configuration to lsb_first 0, last_chip_first 1, brightness 10, output_enable 0.
module led_shift_register_frame_driver #(
    parameter int CHIPS      = 4,
    parameter int PWM_PERIOD = 1000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lsfd_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lsfd_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_we,
    input  logic [lsfd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lsfd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    lsfd_pkg::t_dp_cmd    w_cmd;
    lsfd_pkg::t_dp_status w_status;

    // Controller.
    lsfd_ctrl #(
        .CHIPS (CHIPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_word.opcode),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    lsfd_dp #(
        .CHIPS      (CHIPS),
        .PWM_PERIOD (PWM_PERIOD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

### src/lsfd_checker.sv
// Port-level checks for the frame driver, bound to the top level.
module lsfd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input lsfd_pkg::t_in_word                i_in_word,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input lsfd_pkg::t_out_word               o_out_word,
    input logic                              i_cfg_we
);

    logic w_in_acc;
    logic w_is_refresh;

    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_is_refresh = (i_in_word.opcode == lsfd_pkg::OP_REFRESH);

    // A stalled result holds its word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // A bus operation other than refresh yields one final, non-bit result next cycle.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_is_refresh |=> o_out_valid && o_out_word.last
                                      && !o_out_word.bit_valid)
        else $error("single result missing after a bus word");

    // A refresh holds off the input while its bits go out.
    a_refresh_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_is_refresh |=> !o_in_ready)
        else $error("input taken during refresh");

    // Shifted bits never carry an error or read data.
    a_bit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.bit_valid |-> !o_out_word.status
                                                && (o_out_word.read_data == '0))
        else $error("refresh bit carries status or read data");

    // Config writes must come only with no result pending and the block idle; the block does not enforce it.
    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_out_valid && o_in_ready)
        else $error("configuration written while a word is in flight");

endmodule

bind led_shift_register_frame_driver lsfd_checker u_lsfd_checker (.*);
